### rtl/tsst_pkg.sv
// Shared types and constants for the TDMA superframe sync tracker.
`default_nettype none

package tsst_pkg;

   // register field widths
   localparam int LENGTH_W   = 24;
   localparam int SLOT_W     = 16;
   localparam int PREFIX_W   = 16;
   localparam int UNITS_W    = 16;
   localparam int LIMIT_W    = 8;
   localparam int RELOAD_W   = 25;
   localparam int COUNT_W    = 32;
   localparam int ID_W       = 8;
   localparam int TIME_W     = 32;
   localparam int FRAME_W    = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // divider geometry
   localparam int DIV_W     = TIME_W;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   // slot product plus transmit prefix: (2*id+1)*slot + prefix
   localparam int SLOT_SUM_W = ID_W + 1 + SLOT_W + 1;
   // largest beacon target: slot sum plus quotient
   localparam int TARGET_W   = TIME_W + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LENGTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREFIX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNITS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGING = 3'd5;

   // register reset values
   localparam logic [LENGTH_W-1:0] LENGTH_RST = 24'd100000;
   localparam logic [SLOT_W-1:0]   SLOT_RST   = 16'd1000;
   localparam logic [PREFIX_W-1:0] PREFIX_RST = 16'd200;
   localparam logic [UNITS_W-1:0]  UNITS_RST  = 16'd256;
   localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 8'd5;

   // saturation points of the small counters
   localparam logic [LIMIT_W-1:0] SMALL_MAX = 8'hFF;

   // command codes
   localparam logic CMD_TICK   = 1'b0;
   localparam logic CMD_BEACON = 1'b1;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

`default_nettype wire

### rtl/tsst_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none

module tsst_div
   import tsst_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [DIV_W-1:0]   dividend,
   input  wire logic [UNITS_W-1:0] divisor,
   output div_sts_type             status,
   output logic [DIV_W-1:0]        quotient
);

   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 done_ff, done_in;
   logic [UNITS_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [UNITS_W-1:0]   divisor_ff, divisor_in;
   logic [UNITS_W:0]     shifted;
   logic [UNITS_W:0]     trial;
   logic                 fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted    = {rem_ff, quo_ff[DIV_W-1]};
      trial      = shifted - {1'b0, divisor_ff};
      fits       = shifted >= {1'b0, divisor_ff};
      count_in   = count_ff;
      done_in    = 1'b0;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         count_in   = DIV_CNT_W'(DIV_W);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == DIV_CNT_W'(1));
         rem_in   = fits ? trial[UNITS_W-1:0] : shifted[UNITS_W-1:0];
         quo_in   = {quo_ff[DIV_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

### rtl/tdma_superframe_sync_tracker_unit.sv
// TDMA superframe sync tracker: timer, beacon realignment and result register.
// Usage:
//   req_* carries one word per event: req_tuser is the command (tick or
//   beacon), req_tdata the beacon fields. rsp_* returns exactly one word for
//   each accepted request, in order; csr_* writes the six registers.
//   A tick goes from acceptance straight to the loading state, a beacon
//   through the divide state first: the timestamp difference is divided by
//   the units per microsecond in a serial divider that produces one quotient
//   bit a cycle. One request is in work at a time; req_tready is high again
//   in the cycle after the result is loaded.
//   The result register holds a finished word while the next request is
//   taken and worked on; if the receiver still stalls when that next word is
//   ready, the block waits with req_tready low until the register frees.
//   Reset (synchronous, active high) restores the register defaults, enters
//   discovery, clears all counters and empties the result register.
//   Registers must be written only while no request is in work; not enforced.
`default_nettype none

module tdma_superframe_sync_tracker_unit
   import tsst_pkg::*;
#(
   parameter int FRAME_TIMER_BITS = 24
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: anchor_id[7:0], rx_time[39:8], now_time[71:40], round_id[79:72]
   input  wire logic [79:0]           req_tdata,
   // tuser: command[0]
   input  wire logic [0:0]            req_tuser,
   // response channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: superframe_id[7:0], superframe_count[39:8], frame_time_us[63:40]
   output logic [63:0]                rsp_tdata,
   // tuser: superframe_begin[0], synchronized[1], sync_lost[2],
   //        forward_ranging[3]
   output logic [3:0]                 rsp_tuser,
   // register write port
   input  wire logic                  csr_wen,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FTB  = FRAME_TIMER_BITS;
   // compare width for next tick against the reload point
   localparam int CMP_W  = ((FTB + 1 > RELOAD_W) ? FTB + 1 : RELOAD_W) + 1;
   // width of frame base (length + elapsed) and beacon target
   localparam int BASE_W = ((FTB > LENGTH_W) ? FTB : LENGTH_W) + 1;
   localparam int SUM_W  = ((BASE_W > TARGET_W) ? BASE_W : TARGET_W) + 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EXEC = 3'b100
   } state_type;

   // registers
   logic [LENGTH_W-1:0] length_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [PREFIX_W-1:0] prefix_ff;
   logic [UNITS_W-1:0]  units_ff;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                ranging_ff;

   // sequencer and latched request
   state_type           state_ff, state_in;
   logic                cmd_ff;
   logic [ID_W-1:0]     anchor_ff;
   logic [ID_W-1:0]     round_ff;
   logic [SLOT_SUM_W-1:0] slot_sum_ff;

   // tracker state
   logic                sync_ff, sync_in;
   logic [FTB-1:0]      elapsed_ff, elapsed_in;
   logic [RELOAD_W-1:0] reload_ff, reload_in;
   logic [COUNT_W-1:0]  counter_ff, counter_in;
   logic [LIMIT_W-1:0]  beacons_ff, beacons_in;
   logic [LIMIT_W-1:0]  missed_ff, missed_in;
   logic [ID_W-1:0]     last_id_ff, last_id_in;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3:0]          rsp_flags_ff, rsp_flags_in;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic [FRAME_W-1:0]  rsp_time_ff;

   // divider hookup
   div_sts_type         div_sts;
   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [UNITS_W-1:0]  div_divisor;
   logic [DIV_W-1:0]    div_quotient;

   logic                accept;
   logic                load;
   logic [CMP_W-1:0]    next_ext;
   logic [CMP_W-1:0]    reload_ext;
   logic [CMP_W-1:0]    elapsed_out;
   logic                begin_sf;
   logic                lost;
   logic                fwd;
   logic [LIMIT_W-1:0]  missed_sat;
   logic [SUM_W-1:0]    base;
   logic [SUM_W-1:0]    target;
   logic [SUM_W-1:0]    gap;

   assign accept = req_tvalid && req_tready;
   assign load   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff  <= LENGTH_RST;
         slot_ff    <= SLOT_RST;
         prefix_ff  <= PREFIX_RST;
         units_ff   <= UNITS_RST;
         limit_ff   <= LIMIT_RST;
         ranging_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_LENGTH:  length_ff  <= csr_wdata[LENGTH_W-1:0];
            CSR_SLOT:    slot_ff    <= csr_wdata[SLOT_W-1:0];
            CSR_PREFIX:  prefix_ff  <= csr_wdata[PREFIX_W-1:0];
            CSR_UNITS:   units_ff   <= csr_wdata[UNITS_W-1:0];
            CSR_LIMIT:   limit_ff   <= csr_wdata[LIMIT_W-1:0];
            CSR_RANGING: ranging_ff <= csr_wdata[0];
            default:     ;
         endcase
      end
   end

   // divider start: timestamp difference mod 2^32, zero divisor acts as one
   assign div_start    = accept && (req_tuser[0] == CMD_BEACON);
   assign div_dividend = req_tdata[71:40] - req_tdata[39:8];
   assign div_divisor  = (units_ff == '0) ? UNITS_W'(1) : units_ff;

   tsst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_sts),
      .quotient (div_quotient)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept)
               state_in = (req_tuser[0] == CMD_BEACON) ? ST_DIV : ST_EXEC;
         end
         ST_DIV: begin
            if (div_sts.done)
               state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (load)
               state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   // update of the tracker state and the result word
   always_comb begin
      next_ext    = {{(CMP_W - FTB){1'b0}}, elapsed_ff} + CMP_W'(1);
      reload_ext  = {{(CMP_W - RELOAD_W){1'b0}}, reload_ff};
      begin_sf    = (&elapsed_ff) || (next_ext >= reload_ext);
      missed_sat  = (missed_ff != SMALL_MAX) ? missed_ff + 1'b1 : missed_ff;
      base        = {{(SUM_W - LENGTH_W){1'b0}}, length_ff}
                  + {{(SUM_W - FTB){1'b0}}, elapsed_ff};
      target      = {{(SUM_W - SLOT_SUM_W){1'b0}}, slot_sum_ff}
                  + {{(SUM_W - DIV_W){1'b0}}, div_quotient};
      gap         = base - target;

      sync_in     = sync_ff;
      elapsed_in  = elapsed_ff;
      reload_in   = reload_ff;
      counter_in  = counter_ff;
      beacons_in  = beacons_ff;
      missed_in   = missed_ff;
      last_id_in  = last_id_ff;
      lost        = 1'b0;
      fwd         = 1'b0;

      if (cmd_ff == CMD_TICK) begin
         if (begin_sf) begin
            elapsed_in = '0;
            reload_in  = {1'b0, length_ff};
            if (counter_ff != '1)
               counter_in = counter_ff + 1'b1;
            if (beacons_ff == '0) begin
               missed_in = missed_sat;
            end
            if ((beacons_ff == '0) && (missed_sat > limit_ff)) begin
               // too many beaconless superframes: back to discovery
               lost       = sync_ff;
               sync_in    = 1'b0;
               counter_in = '0;
            end else begin
               beacons_in = '0;
            end
         end else begin
            elapsed_in = next_ext[FTB-1:0];
         end
      end else begin
         // beacon: realign the reload point, clamp at zero when overshot
         reload_in  = (target >= base) ? '0 : gap[RELOAD_W-1:0];
         last_id_in = round_ff;
         if (sync_ff) begin
            if (beacons_ff != SMALL_MAX)
               beacons_in = beacons_ff + 1'b1;
            missed_in = '0;
            fwd       = ranging_ff;
         end else begin
            sync_in = 1'b1;
         end
      end

      elapsed_out  = {{(CMP_W - FTB){1'b0}}, elapsed_in};
      rsp_flags_in = {fwd, lost, sync_in, (cmd_ff == CMD_TICK) && begin_sf};

      rsp_valid_in = rsp_valid_ff;
      if (load)
         rsp_valid_in = 1'b1;
      else if (rsp_tready)
         rsp_valid_in = 1'b0;
   end

   // control and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sync_ff      <= 1'b0;
         elapsed_ff   <= '0;
         reload_ff    <= {1'b0, LENGTH_RST};
         counter_ff   <= '0;
         beacons_ff   <= '0;
         missed_ff    <= '0;
         last_id_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            sync_ff    <= sync_in;
            elapsed_ff <= elapsed_in;
            reload_ff  <= reload_in;
            counter_ff <= counter_in;
            beacons_ff <= beacons_in;
            missed_ff  <= missed_in;
            last_id_ff <= last_id_in;
         end
      end
   end

   // latched request, slot product and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_tuser[0];
         anchor_ff <= req_tdata[7:0];
         round_ff  <= req_tdata[79:72];
      end
      if (state_ff == ST_DIV)
         slot_sum_ff <= SLOT_SUM_W'({anchor_ff, 1'b1}) * SLOT_SUM_W'(slot_ff)
                      + {{(SLOT_SUM_W - PREFIX_W){1'b0}}, prefix_ff};
      if (load) begin
         rsp_flags_ff <= rsp_flags_in;
         rsp_id_ff    <= last_id_in;
         rsp_count_ff <= counter_in;
         rsp_time_ff  <= elapsed_out[FRAME_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flags_ff;
   assign rsp_tdata  = {rsp_time_ff, rsp_count_ff, rsp_id_ff};

endmodule

`default_nettype wire

### bench/tb_tdma_superframe_sync_tracker_unit.sv
// Self-checking bench for the TDMA superframe sync tracker: predictor, stimulus, checks.
`timescale 1ns / 1ps

module tb_tdma_superframe_sync_tracker_unit;
   import tsst_pkg::*;

   localparam int ITEMS_PER_PHASE = 125;
   localparam int PHASES          = 10;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int MAX_REPORTS     = 10;

   // last value the frame timer can hold before it is forced to wrap
   localparam logic [FRAME_W:0] TIMER_TOP = {1'b0, {FRAME_W{1'b1}}};

   // register write order, one write per register in every phase but the first
   localparam logic [CSR_IDX_W-1:0] REG_ORDER [6] = '{
      CSR_LENGTH, CSR_SLOT, CSR_PREFIX, CSR_UNITS, CSR_LIMIT, CSR_RANGING
   };

   // one request word, unpacked
   typedef struct packed {
      logic              cmd;
      logic [ID_W-1:0]   anchor;
      logic [TIME_W-1:0] rx;
      logic [TIME_W-1:0] now;
      logic [ID_W-1:0]   round;
   } request_type;

   // one status word, unpacked
   typedef struct packed {
      logic               frame_begin;
      logic               synced;
      logic               lost;
      logic               forward;
      logic [ID_W-1:0]    round;
      logic [COUNT_W-1:0] count;
      logic [FRAME_W-1:0] frame_time;
   } status_type;

   // Tracker predictor plus the queue of status words still owed by the block
   class superframe_checker;
      // register copies
      logic [LENGTH_W-1:0] frame_len;
      logic [SLOT_W-1:0]   slot_len;
      logic [PREFIX_W-1:0] prefix_len;
      logic [UNITS_W-1:0]  units;
      logic [LIMIT_W-1:0]  miss_limit;
      logic                ranging;
      // tracker state
      logic                synced;
      logic [FRAME_W-1:0]  elapsed;
      logic [RELOAD_W-1:0] reload;
      logic [COUNT_W-1:0]  sf_count;
      logic [7:0]          beacons;
      logic [7:0]          misses;
      logic [ID_W-1:0]     round;
      status_type          expected_status[$];
      int                  mismatches;

      function new();
         frame_len  = LENGTH_RST;
         slot_len   = SLOT_RST;
         prefix_len = PREFIX_RST;
         units      = UNITS_RST;
         miss_limit = LIMIT_RST;
         ranging    = 1'b0;
         synced     = 1'b0;
         elapsed    = '0;
         reload     = RELOAD_W'(LENGTH_RST);
         sf_count   = '0;
         beacons    = '0;
         misses     = '0;
         round      = '0;
         mismatches = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_LENGTH:  frame_len  = value[LENGTH_W-1:0];
            CSR_SLOT:    slot_len   = value[SLOT_W-1:0];
            CSR_PREFIX:  prefix_len = value[PREFIX_W-1:0];
            CSR_UNITS:   units      = value[UNITS_W-1:0];
            CSR_LIMIT:   miss_limit = value[LIMIT_W-1:0];
            CSR_RANGING: ranging    = value[0];
            default: ;
         endcase
      endfunction

      // Frame wrap; returns 1 when it drops a synced tracker into discovery
      function logic start_superframe();
         logic dropped;
         dropped = 1'b0;
         elapsed = '0;
         reload  = RELOAD_W'(frame_len);
         if (sf_count != '1) sf_count++;
         if (beacons == '0) begin
            if (misses != SMALL_MAX) misses++;
            if (misses > miss_limit) begin
               // beacon count is left alone on this path
               dropped  = synced;
               synced   = 1'b0;
               sf_count = '0;
               return dropped;
            end
         end
         beacons = '0;
         return dropped;
      endfunction

      // Beacon realignment: reload = length + elapsed - target, clamped at zero
      function void realign(logic [ID_W-1:0] anchor, logic [TIME_W-1:0] rx,
                            logic [TIME_W-1:0] now);
         logic [TIME_W-1:0] diff;
         logic [63:0]       divisor;
         logic [63:0]       delay;
         logic [63:0]       target;
         logic [63:0]       base;
         diff    = now - rx;
         divisor = (units == '0) ? 64'd1 : 64'(units);
         delay   = 64'(diff) / divisor + 64'(prefix_len);
         target  = (64'(anchor) * 64'd2 + 64'd1) * 64'(slot_len) + delay;
         base    = 64'(frame_len) + 64'(elapsed);
         reload  = (target >= base) ? '0 : RELOAD_W'(base - target);
      endfunction

      // Predict the status word for an accepted request
      function void note_request(request_type r);
         status_type       s;
         logic [FRAME_W:0] next;
         s.frame_begin = 1'b0;
         s.lost        = 1'b0;
         s.forward     = 1'b0;
         if (r.cmd == CMD_TICK) begin
            next = {1'b0, elapsed} + 1'b1;
            if (next >= reload || next > TIMER_TOP) begin
               s.frame_begin = 1'b1;
               s.lost        = start_superframe();
            end else begin
               elapsed = next[FRAME_W-1:0];
            end
         end else begin
            realign(r.anchor, r.rx, r.now);
            round = r.round;
            if (synced) begin
               if (beacons != SMALL_MAX) beacons++;
               misses    = '0;
               s.forward = ranging;
            end else begin
               // first beacon in discovery only locks
               synced = 1'b1;
            end
         end
         s.synced     = synced;
         s.round      = round;
         s.count      = sf_count;
         s.frame_time = elapsed;
         expected_status.push_back(s);
      endfunction

      // Compare an accepted status word with the oldest prediction
      function void check_status(logic [63:0] tdata, logic [3:0] tuser);
         status_type got;
         status_type want;
         got.frame_begin = tuser[0];
         got.synced      = tuser[1];
         got.lost        = tuser[2];
         got.forward     = tuser[3];
         got.round       = tdata[7:0];
         got.count       = tdata[39:8];
         got.frame_time  = tdata[63:40];
         if (expected_status.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: status word with none pending: tdata=%h tuser=%b",
                        $time, tdata, tuser);
            return;
         end
         want = expected_status.pop_front();
         if (got.frame_begin !== want.frame_begin || got.synced !== want.synced ||
             got.lost !== want.lost || got.forward !== want.forward ||
             got.round !== want.round || got.count !== want.count ||
             got.frame_time !== want.frame_time) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: status mismatch: expected begin=%b sync=%b lost=%b fwd=%b",
                        $time, want.frame_begin, want.synced, want.lost, want.forward,
                        " id=%0d count=%0d time=%0d, got begin=%b sync=%b lost=%b",
                        want.round, want.count, want.frame_time,
                        got.frame_begin, got.synced, got.lost,
                        " fwd=%b id=%0d count=%0d time=%0d",
                        got.forward, got.round, got.count, got.frame_time);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // tdata: anchor_id[7:0], rx_time[39:8], now_time[71:40], round_id[79:72]
   logic [79:0]           req_tdata = '0;
   // tuser: command[0]
   logic [0:0]            req_tuser = CMD_TICK;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // tdata: superframe_id[7:0], superframe_count[39:8], frame_time_us[63:40]
   logic [63:0]           rsp_tdata;
   // tuser: superframe_begin[0], synchronized[1], sync_lost[2], forward_ranging[3]
   logic [3:0]            rsp_tuser;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_LENGTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int                    cycle_count = 0;
   logic                  sender_burst = 1'b0;
   logic                  receiver_burst = 1'b0;
   superframe_checker     tracker;

   tdma_superframe_sync_tracker_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic request_type make_request(logic cmd, logic [ID_W-1:0] anchor,
                                                logic [TIME_W-1:0] rx,
                                                logic [TIME_W-1:0] now,
                                                logic [ID_W-1:0] round);
      request_type r;
      r.cmd    = cmd;
      r.anchor = anchor;
      r.rx     = rx;
      r.now    = now;
      r.round  = round;
      return r;
   endfunction

   // Random tick or beacon; beacon delays mostly land at zero to six microseconds plus up to three units
   function automatic request_type random_request(int beacon_pct);
      request_type       r;
      logic [TIME_W-1:0] span;
      r.cmd    = ($urandom_range(0, 99) < beacon_pct) ? CMD_BEACON : CMD_TICK;
      r.anchor = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 3));
      r.rx     = $urandom;
      r.round  = ID_W'($urandom);
      span     = (tracker.units == '0) ? TIME_W'(1) : TIME_W'(tracker.units);
      if ($urandom_range(0, 3) == 0)
         r.now = $urandom;
      else
         r.now = r.rx + span * TIME_W'($urandom_range(0, 6)) + TIME_W'($urandom_range(0, 3));
      return r;
   endfunction

   // Drive one request word and wait for it to be taken
   task automatic send_request(input request_type r);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.cmd;
      req_tdata  <= {r.round, r.now, r.rx, r.anchor};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      tracker.note_request(r);
   endtask

   // Write all six registers for a phase; block is idle here
   task automatic configure_phase(input int phase);
      logic [CSR_DATA_W-1:0] values [6];
      case (phase)
         1: values = '{24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1};
         2: values = '{24'd16, 24'd1, 24'd0, 24'd65535, 24'd2, 24'd1};
         3: values = '{24'd50, 24'd3, 24'd5, 24'd1000, 24'd254, 24'd0};
         4: values = '{24'd16777215, 24'd65535, 24'd65535, 24'd1, 24'd254, 24'd1};
         5: values = '{24'd1, 24'd2, 24'd1, 24'd256, 24'd255, 24'd0};
         default: begin
            values[0] = CSR_DATA_W'($urandom_range(0, 60));
            values[1] = CSR_DATA_W'($urandom_range(1, 6));
            values[2] = CSR_DATA_W'($urandom_range(0, 4));
            values[3] = ($urandom_range(0, 3) == 0) ? '0
                                                    : CSR_DATA_W'($urandom_range(1, 65535));
            values[4] = CSR_DATA_W'($urandom_range(0, 4));
            values[5] = CSR_DATA_W'($urandom_range(0, 1));
         end
      endcase
      for (int i = 0; i < 6; i++) begin
         csr_wen   <= 1'b1;
         csr_index <= REG_ORDER[i];
         csr_wdata <= values[i];
         @(posedge clock);
         tracker.set_register(REG_ORDER[i], values[i]);
      end
      csr_wen <= 1'b0;
   endtask

   // Status side: random stalls, with stall-free stretches
   initial begin
      int stall;
      int words;
      words = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (words % 24 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
         stall = receiver_burst ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (rsp_tvalid !== 1'b1) @(posedge clock);
         tracker.check_status(rsp_tdata, rsp_tuser);
         words++;
      end
   end

   // Reset, directed words, then phases of random traffic
   initial begin
      int beacon_pct;
      beacon_pct = 10;
      tracker    = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset registers: lock, far beacon with clamped-to-zero reload, wrap in diff
      send_request(make_request(CMD_TICK, '0, '0, '0, '0));
      send_request(make_request(CMD_BEACON, 8'd0, 32'd0, 32'd0, 8'd0));
      send_request(make_request(CMD_BEACON, 8'd255, 32'd0, 32'hFFFF_FFFF, 8'd255));
      send_request(make_request(CMD_TICK, '0, '0, '0, '0));
      send_request(make_request(CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      send_request(make_request(CMD_BEACON, 8'd0, 32'hFFFF_FFFF, 32'd0, 8'hA5));
      send_request(make_request(CMD_BEACON, 8'h5A, 32'h1234_5678, 32'h1234_5678, 8'h5A));
      send_request(make_request(CMD_TICK, '0, '0, '0, '0));
      send_request(make_request(CMD_TICK, '0, '0, '0, '0));

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) configure_phase(phase);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // reshuffle beacon density and sender pacing every 32 words
            if (i % 32 == 0) begin
               sender_burst = ($urandom_range(0, 3) == 0);
               case ($urandom_range(0, 3))
                  0: beacon_pct = 0;
                  1: beacon_pct = 5;
                  2: beacon_pct = 20;
                  default: beacon_pct = 50;
               endcase
            end
            send_request(random_request(beacon_pct));
         end
         req_tvalid <= 1'b0;
         while (tracker.expected_status.size() != 0) @(posedge clock);
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.expected_status.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### sim.f
rtl/tsst_pkg.sv
rtl/tsst_div.sv
rtl/tdma_superframe_sync_tracker_unit.sv
bench/tb_tdma_superframe_sync_tracker_unit.sv
